### design/tisd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tisd_pkg
// Types and constants of the triangle index stream decoder: item structs,
// ring types, the decode phase and the byte codes of the index stream.
// ----------------------------------------------------------------------------
package tisd_pkg;

  localparam int RING_DEPTH     = 16;
  localparam int RING_BITS      = $clog2(RING_DEPTH);
  localparam int IDX_W          = 32;
  localparam int TOTAL_W        = 24;
  localparam int COUNT_BITS_DEF = 24;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_AUX_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AUX_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL    = 2'd3;

  // byte codes
  localparam logic [7:0] CODE_FIXED_MIN = 8'hf0;  // first code that uses the aux table
  localparam logic [7:0] CODE_AUX_NEW   = 8'hfe;  // aux byte follows, first corner new
  localparam logic [7:0] CODE_AUX_EXPL  = 8'hff;  // aux byte follows, first corner explicit
  localparam logic [3:0] NIB_NEW        = 4'h0;   // corner is the next new vertex
  localparam logic [3:0] NIB_EXPLICIT   = 4'hf;   // corner is an explicit index
  localparam logic [7:0] GROUP_CONT     = 8'h80;  // varint continuation bit
  localparam logic [2:0] LAST_GROUP     = 3'd4;   // fifth group always ends the value
  localparam logic [15:0] NARROW_MASK   = 16'hffff;

  typedef logic [RING_DEPTH-1:0][IDX_W-1:0]   vring_t;
  typedef logic [RING_DEPTH-1:0][2*IDX_W-1:0] ering_t;
  typedef logic [7:0][7:0]                    aux_word_t;

  typedef enum logic [4:0] {
    PH_CODE = 5'b00001,
    PH_AUX  = 5'b00010,
    PH_VAR0 = 5'b00100,
    PH_VAR1 = 5'b01000,
    PH_VAR2 = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic             tri_valid;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic             last_triangle;
    logic             want_data;
    logic             wrong_kind;
  } out_item_t;

endpackage
`default_nettype wire

### design/triangle_index_stream_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_index_stream_decoder_core
// Byte-serial decoder of an edge/vertex FIFO compressed triangle index stream.
// Each accepted byte yields one result item: a completed triangle (if any),
// the kind of byte wanted next and a wrong-kind flag.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  -------------------------------
//  in        in   in_valid / in_ready     in_item  (req_type, in_byte)
//  out       out  out_valid / out_ready   out_item (triangle, want, error)
//  cfg       in   cfg_write               cfg_index, cfg_data (64 bits)
//
//  one item per cycle sustained while out_ready stays high; an accepted item
//  goes into the input register, then its result into the result register,
//  where it is offered until out_ready takes it
//  the rate is set by the per-byte state update: rings, vertex counter and
//  varint accumulator all settle in one pass between the two registers
//  reset (rst, synchronous) clears rings, counters, phase and both stages
//  out_ready low holds the result; one more item waits in the input
//  register, after which in_ready drops
//
module triangle_index_stream_decoder_core
  import tisd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_item,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // vertex ring kept relative to the write slot: entry k is k places back,
  // so writing a vertex sets entry 0 and advancing rotates by one
  function automatic vring_t vpush(input vring_t r, input logic [IDX_W-1:0] v,
                                   input logic adv);
    vring_t t;
    t    = r;
    t[0] = v;
    if (adv) begin
      t = {t[RING_DEPTH-2:0], t[RING_DEPTH-1]};
    end
    return t;
  endfunction

  // edge ring: entry 0 is the most recent edge, plain shift line
  function automatic ering_t epush(input ering_t r, input logic [IDX_W-1:0] x,
                                   input logic [IDX_W-1:0] y);
    return {r[RING_DEPTH-2:0], y, x};
  endfunction

  // next phase: first explicit corner at or after corner k
  function automatic phase_t explicit_after(input logic [7:0] code,
                                            input logic [7:0] aux,
                                            input logic [1:0] k);
    logic   e0, e1, e2;
    phase_t ph;
    if (code < CODE_FIXED_MIN) begin
      e0 = 1'b0;
      e1 = 1'b0;
      e2 = 1'b1;
    end else begin
      e0 = (code == CODE_AUX_EXPL);
      e1 = (aux[7:4] == NIB_EXPLICIT);
      e2 = (aux[3:0] == NIB_EXPLICIT);
    end
    if (k == 2'd0 && e0) begin
      ph = PH_VAR0;
    end else if (k <= 2'd1 && e1) begin
      ph = PH_VAR1;
    end else if (k <= 2'd2 && e2) begin
      ph = PH_VAR2;
    end else begin
      ph = PH_CODE;
    end
    return ph;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  aux_word_t          aux_low;
  aux_word_t          aux_high;
  logic               wide_indices;
  logic [TOTAL_W-1:0] triangle_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      aux_low        <= '0;
      aux_high       <= '0;
      wide_indices   <= 1'b1;
      triangle_total <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AUX_LOW:  aux_low        <= cfg_data;
        REG_AUX_HIGH: aux_high       <= cfg_data;
        REG_WIDE:     wide_indices   <= cfg_data[0];
        REG_TOTAL:    triangle_total <= cfg_data[TOTAL_W-1:0];
        default:      ;
      endcase
    end
  end

  // triangle total reduced or extended to the counter width
  logic [COUNT_BITS+TOTAL_W-1:0] total_ext;
  logic [COUNT_BITS-1:0]         total_cmp;
  assign total_ext = {{COUNT_BITS{1'b0}}, triangle_total};
  assign total_cmp = total_ext[COUNT_BITS-1:0];

  // --------------------------------------------------------------------------
  // input register and stage handshake
  // --------------------------------------------------------------------------
  logic     stage_valid;
  in_item_t stage_item;
  logic     advance;

  // the decode pass fires when the result register is free or being emptied
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  // --------------------------------------------------------------------------
  // decoder state
  // --------------------------------------------------------------------------
  vring_t           vring, vring_next;
  ering_t           ering, ering_next;
  logic [IDX_W-1:0] next_new_vertex, next_new_vertex_next;
  logic [IDX_W-1:0] last_explicit, last_explicit_next;
  phase_t           phase, phase_next;
  logic [7:0]       held_code, held_code_next;
  logic [7:0]       held_aux, held_aux_next;
  logic [IDX_W-1:0] varint_accum, varint_accum_next;
  logic [2:0]       varint_groups, varint_groups_next;
  logic [IDX_W-1:0] held_a, held_a_next;
  logic [IDX_W-1:0] held_b, held_b_next;
  logic [IDX_W-1:0] held_c, held_c_next;
  logic [COUNT_BITS-1:0] triangles_done, triangles_done_next;

  // --------------------------------------------------------------------------
  // single-pass decode of the staged byte
  // --------------------------------------------------------------------------
  logic                 want;
  logic [7:0]           byte_val;
  logic [3:0]           nib_b, nib_c;
  logic [RING_BITS-1:0] back_idx;
  logic [2*IDX_W-1:0]   edge_sel;
  aux_word_t            aux_word;
  logic [7:0]           aux_val;
  logic                 inc_a, inc_b, inc_c;
  logic [IDX_W-1:0]     ca, cb, cc;
  logic                 do_emit, do_finish;
  logic [IDX_W-1:0]     ea, eb, ec;
  logic [IDX_W+6:0]     group_shifted;
  logic [IDX_W-1:0]     accum_new, zz_delta, expl_val;
  logic [1:0]           corner;
  phase_t               ph_after;
  logic [COUNT_BITS-1:0] count_new;
  logic [IDX_W-1:0]     idx_mask;
  out_item_t            result;

  always_comb begin
    vring_next           = vring;
    ering_next           = ering;
    next_new_vertex_next = next_new_vertex;
    last_explicit_next   = last_explicit;
    phase_next           = phase;
    held_code_next       = held_code;
    held_aux_next        = held_aux;
    varint_accum_next    = varint_accum;
    varint_groups_next   = varint_groups;
    held_a_next          = held_a;
    held_b_next          = held_b;
    held_c_next          = held_c;
    triangles_done_next  = triangles_done;

    want      = (phase != PH_CODE);
    byte_val  = stage_item.in_byte;
    nib_b     = byte_val[7:4];
    nib_c     = byte_val[3:0];
    back_idx  = nib_c + 4'd1;
    edge_sel  = ering[nib_b];
    aux_word  = byte_val[3] ? aux_high : aux_low;
    aux_val   = aux_word[byte_val[2:0]];
    inc_a     = 1'b0;
    inc_b     = 1'b0;
    inc_c     = 1'b0;
    ca        = '0;
    cb        = '0;
    cc        = '0;
    do_emit   = 1'b0;
    do_finish = 1'b0;
    ea        = '0;
    eb        = '0;
    ec        = '0;
    accum_new = varint_accum;
    zz_delta  = '0;
    expl_val  = last_explicit;
    corner    = 2'd0;
    ph_after  = PH_CODE;
    result    = '0;

    // varint group placed at 7 bits per group seen so far, overflow dropped
    case (varint_groups)
      3'd0:    group_shifted = {32'd0, byte_val[6:0]};
      3'd1:    group_shifted = {25'd0, byte_val[6:0], 7'd0};
      3'd2:    group_shifted = {18'd0, byte_val[6:0], 14'd0};
      3'd3:    group_shifted = {11'd0, byte_val[6:0], 21'd0};
      3'd4:    group_shifted = {4'd0, byte_val[6:0], 28'd0};
      default: group_shifted = '0;
    endcase

    if (stage_item.req_type != want) begin
      // wrong kind of byte: dropped, state untouched
      result.wrong_kind = 1'b1;
    end else begin
      unique case (phase)
        PH_CODE: begin
          held_code_next = byte_val;
          if (byte_val < CODE_FIXED_MIN) begin
            // edge from the edge ring plus a third corner
            ca = edge_sel[IDX_W-1:0];
            cb = edge_sel[2*IDX_W-1:IDX_W];
            if (nib_c != NIB_EXPLICIT) begin
              inc_c = (nib_c == NIB_NEW);
              cc    = inc_c ? next_new_vertex : vring[back_idx];
              next_new_vertex_next = next_new_vertex + {31'd0, inc_c};
              do_emit    = 1'b1;
              ea         = ca;
              eb         = cb;
              ec         = cc;
              vring_next = vpush(vring, cc, inc_c);
              ering_next = epush(epush(ering, cc, cb), ca, cc);
            end else begin
              held_a_next        = ca;
              held_b_next        = cb;
              phase_next         = PH_VAR2;
              varint_accum_next  = '0;
              varint_groups_next = '0;
            end
          end else if (byte_val < CODE_AUX_NEW) begin
            // corners from the aux table, first corner always new
            inc_b = (aux_val[7:4] == NIB_NEW);
            inc_c = (aux_val[3:0] == NIB_NEW);
            ca = next_new_vertex;
            cb = inc_b ? (next_new_vertex + 32'd1) : vring[aux_val[7:4]];
            cc = inc_c ? (next_new_vertex + 32'd1 + {31'd0, inc_b})
                       : vring[aux_val[3:0]];
            next_new_vertex_next = next_new_vertex + 32'd1 + {31'd0, inc_b}
                                   + {31'd0, inc_c};
            do_emit    = 1'b1;
            ea         = ca;
            eb         = cb;
            ec         = cc;
            vring_next = vpush(vpush(vpush(vring, ca, 1'b1), cb, inc_b), cc, inc_c);
            ering_next = epush(epush(epush(ering, cb, ca), cc, cb), ca, cc);
          end else begin
            phase_next = PH_AUX;
          end
        end

        PH_AUX: begin
          held_aux_next = byte_val;
          inc_a = (held_code == CODE_AUX_NEW);
          inc_b = (nib_b == NIB_NEW);
          inc_c = (nib_c == NIB_NEW);
          ca = inc_a ? next_new_vertex : '0;
          cb = inc_b ? (next_new_vertex + {31'd0, inc_a}) : vring[nib_b];
          cc = inc_c ? (next_new_vertex + {31'd0, inc_a} + {31'd0, inc_b})
                     : vring[nib_c];
          next_new_vertex_next = next_new_vertex + {31'd0, inc_a} + {31'd0, inc_b}
                                 + {31'd0, inc_c};
          held_a_next = ca;
          held_b_next = cb;
          held_c_next = cc;
          ph_after    = explicit_after(held_code, byte_val, 2'd0);
          if (ph_after == PH_CODE) begin
            do_finish = 1'b1;
          end else begin
            phase_next         = ph_after;
            varint_accum_next  = '0;
            varint_groups_next = '0;
          end
        end

        PH_VAR0, PH_VAR1, PH_VAR2: begin
          corner    = (phase == PH_VAR0) ? 2'd0 : ((phase == PH_VAR1) ? 2'd1 : 2'd2);
          accum_new = varint_accum | group_shifted[IDX_W-1:0];
          if (byte_val >= GROUP_CONT && varint_groups < LAST_GROUP) begin
            varint_accum_next  = accum_new;
            varint_groups_next = varint_groups + 3'd1;
          end else begin
            // zigzag delta against the last explicit index
            zz_delta           = {1'b0, accum_new[IDX_W-1:1]} ^ {IDX_W{accum_new[0]}};
            expl_val           = last_explicit + zz_delta;
            last_explicit_next = expl_val;
            case (corner)
              2'd0:    held_a_next = expl_val;
              2'd1:    held_b_next = expl_val;
              default: held_c_next = expl_val;
            endcase
            varint_accum_next  = '0;
            varint_groups_next = '0;
            ph_after = explicit_after(held_code, held_aux, corner + 2'd1);
            if (ph_after == PH_CODE) begin
              do_finish = 1'b1;
            end else begin
              phase_next = ph_after;
            end
          end
        end

        default: phase_next = PH_CODE;
      endcase

      // all corners known: push them and emit
      if (do_finish) begin
        do_emit    = 1'b1;
        ea         = held_a_next;
        eb         = held_b_next;
        ec         = held_c_next;
        phase_next = PH_CODE;
        if (held_code < CODE_FIXED_MIN) begin
          vring_next = vpush(vring, ec, 1'b1);
          ering_next = epush(epush(ering, ec, eb), ea, ec);
        end else begin
          vring_next = vpush(vpush(vpush(vring, ea, 1'b1), eb,
                             held_aux_next[7:4] == NIB_NEW ||
                             held_aux_next[7:4] == NIB_EXPLICIT), ec,
                             held_aux_next[3:0] == NIB_NEW ||
                             held_aux_next[3:0] == NIB_EXPLICIT);
          ering_next = epush(epush(epush(ering, eb, ea), ec, eb), ea, ec);
        end
      end
    end

    // triangle output, narrow mode keeps the low 16 bits
    count_new = triangles_done + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    idx_mask  = wide_indices ? {IDX_W{1'b1}} : {16'd0, NARROW_MASK};
    if (do_emit) begin
      result.tri_valid     = 1'b1;
      result.index_a       = ea & idx_mask;
      result.index_b       = eb & idx_mask;
      result.index_c       = ec & idx_mask;
      result.last_triangle = (count_new == total_cmp);
      triangles_done_next  = count_new;
    end
    result.want_data = (phase_next != PH_CODE);
  end

  // --------------------------------------------------------------------------
  // state and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vring           <= '0;
      ering           <= '0;
      next_new_vertex <= '0;
      last_explicit   <= '0;
      phase           <= PH_CODE;
      held_code       <= '0;
      held_aux        <= '0;
      varint_accum    <= '0;
      varint_groups   <= '0;
      held_a          <= '0;
      held_b          <= '0;
      held_c          <= '0;
      triangles_done  <= '0;
    end else if (advance) begin
      vring           <= vring_next;
      ering           <= ering_next;
      next_new_vertex <= next_new_vertex_next;
      last_explicit   <= last_explicit_next;
      phase           <= phase_next;
      held_code       <= held_code_next;
      held_aux        <= held_aux_next;
      varint_accum    <= varint_accum_next;
      varint_groups   <= varint_groups_next;
      held_a          <= held_a_next;
      held_b          <= held_b_next;
      held_c          <= held_c_next;
      triangles_done  <= triangles_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire

### tb/tb_triangle_index_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_index_stream_decoder_core
// Self-checking bench for the triangle index stream decoder. A behavioral
// decoder of its own (rings, vertex counter, varint assembly, phase) predicts
// the result of every accepted byte; a checker compares each returned item
// field by field against the oldest prediction, under random idling on both
// channels, a long receiver hold-off and a series of register settings.
// ----------------------------------------------------------------------------
module tb_triangle_index_stream_decoder_core;
  import tisd_pkg::*;

  localparam logic KIND_CODE    = 1'b0;
  localparam logic KIND_DATA    = 1'b1;
  localparam int   LONG_STALL   = 60;  // receiver hold-off, long enough to fill both stages
  localparam int   DRAIN_CYCLES = 8;   // idle time after the last predicted item has come back
  localparam int   REPORT_MAX   = 10;

  // ---------------------------------------------------------------------------
  // block ports, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  triangle_index_stream_decoder_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioral decoder state
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]          vtx_ring [RING_DEPTH];
  logic [2*IDX_W-1:0]        edge_ring [RING_DEPTH];  // first index low, second high
  logic [RING_BITS-1:0]      vtx_pos;
  logic [RING_BITS-1:0]      edge_pos;
  logic [IDX_W-1:0]          next_vertex;
  logic [IDX_W-1:0]          last_index;              // last explicit index
  phase_t                    phase;
  logic [7:0]                code_reg;
  logic [7:0]                aux_reg;
  logic [IDX_W-1:0]          group_acc;
  logic [2:0]                group_cnt;
  logic [IDX_W-1:0]          corner [3];
  logic [COUNT_BITS_DEF-1:0] tris_emitted;
  out_item_t                 decode_result;

  // shadow of the register file
  logic [63:0]               aux_lo_cfg;
  logic [63:0]               aux_hi_cfg;
  logic                      wide_cfg;
  logic [TOTAL_W-1:0]        total_cfg;

  // predicted items, oldest first
  out_item_t                 pending_results [$];
  out_item_t                 expected_item;
  int                        mismatches = 0;

  bit                        tx_gaps_on         = 1'b1;
  bit                        rx_gaps_on         = 1'b1;
  bit                        long_stall_pending = 1'b0;

  task automatic reset_model();
    for (int i = 0; i < RING_DEPTH; i++) begin
      vtx_ring[i]  = '0;
      edge_ring[i] = '0;
    end
    vtx_pos      = '0;
    edge_pos     = '0;
    next_vertex  = '0;
    last_index   = '0;
    phase        = PH_CODE;
    code_reg     = '0;
    aux_reg      = '0;
    group_acc    = '0;
    group_cnt    = '0;
    corner[0]    = '0;
    corner[1]    = '0;
    corner[2]    = '0;
    tris_emitted = '0;
    aux_lo_cfg   = '0;
    aux_hi_cfg   = '0;
    wide_cfg     = 1'b1;
    total_cfg    = '0;
  endtask

  function automatic logic [IDX_W-1:0] ring_back(input logic [3:0] back);
    logic [RING_BITS-1:0] slot;
    slot = vtx_pos - back;
    return vtx_ring[slot];
  endfunction

  function automatic logic [IDX_W-1:0] take_new();
    logic [IDX_W-1:0] v;
    v = next_vertex;
    next_vertex = next_vertex + 1'b1;
    return v;
  endfunction

  function automatic void push_vertex(input logic [IDX_W-1:0] v, input logic advance);
    vtx_ring[vtx_pos] = v;
    if (advance) vtx_pos = vtx_pos + 1'b1;
  endfunction

  function automatic void push_edge(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y);
    edge_ring[edge_pos] = {y, x};
    edge_pos = edge_pos + 1'b1;
  endfunction

  function automatic void emit_triangle(input logic [IDX_W-1:0] a, b, c);
    logic [IDX_W-1:0]          mask;
    logic [COUNT_BITS_DEF-1:0] cnt;
    mask = wide_cfg ? '1 : IDX_W'(NARROW_MASK);
    cnt  = tris_emitted + 1'b1;
    decode_result.tri_valid     = 1'b1;
    decode_result.index_a       = a & mask;
    decode_result.index_b       = b & mask;
    decode_result.index_c       = c & mask;
    decode_result.last_triangle = (cnt == COUNT_BITS_DEF'(total_cfg));
    tris_emitted = cnt;
  endfunction

  function automatic logic corner_explicit(input int j);
    if (code_reg < CODE_FIXED_MIN) return j == 2;
    if (j == 0) return code_reg == CODE_AUX_EXPL;
    if (j == 1) return aux_reg[7:4] == NIB_EXPLICIT;
    return aux_reg[3:0] == NIB_EXPLICIT;
  endfunction

  function automatic phase_t explicit_from(input int k);
    for (int j = k; j < 3; j++) begin
      if (corner_explicit(j)) begin
        case (j)
          0:       return PH_VAR0;
          1:       return PH_VAR1;
          default: return PH_VAR2;
        endcase
      end
    end
    return PH_CODE;
  endfunction

  function automatic void start_groups(input phase_t ph);
    phase     = ph;
    group_acc = '0;
    group_cnt = '0;
  endfunction

  // all corners known: update the rings and put the triangle out
  function automatic void close_triangle();
    logic [3:0] feb, fec;
    feb = aux_reg[7:4];
    fec = aux_reg[3:0];
    if (code_reg < CODE_FIXED_MIN) begin
      push_vertex(corner[2], 1'b1);
      push_edge(corner[2], corner[1]);
      push_edge(corner[0], corner[2]);
    end else begin
      push_vertex(corner[0], 1'b1);
      push_vertex(corner[1], feb == NIB_NEW || feb == NIB_EXPLICIT);
      push_vertex(corner[2], fec == NIB_NEW || fec == NIB_EXPLICIT);
      push_edge(corner[1], corner[0]);
      push_edge(corner[2], corner[1]);
      push_edge(corner[0], corner[2]);
    end
    emit_triangle(corner[0], corner[1], corner[2]);
    phase = PH_CODE;
  endfunction

  function automatic void decode_code(input logic [7:0] b);
    logic [RING_BITS-1:0] slot;
    logic [2*IDX_W-1:0]   e;
    logic [7:0]           aux;
    logic [3:0]           feb, fec;
    logic [IDX_W-1:0]     a, bv, c;
    code_reg = b;
    if (b < CODE_FIXED_MIN) begin
      // edge from the edge ring, third corner new, recent or explicit
      slot = edge_pos - 1'b1 - b[7:4];
      e    = edge_ring[slot];
      a    = e[IDX_W-1:0];
      bv   = e[2*IDX_W-1:IDX_W];
      fec  = b[3:0];
      if (fec != NIB_EXPLICIT) begin
        if (fec == NIB_NEW) c = take_new();
        else c = ring_back(fec + 1'b1);
        emit_triangle(a, bv, c);
        push_vertex(c, fec == NIB_NEW);
        push_edge(c, bv);
        push_edge(a, c);
      end else begin
        corner[0] = a;
        corner[1] = bv;
        start_groups(PH_VAR2);
      end
    end else if (b < CODE_AUX_NEW) begin
      // fixed code, corners described by an aux table byte
      aux = b[3] ? aux_hi_cfg[8*b[2:0] +: 8] : aux_lo_cfg[8*b[2:0] +: 8];
      feb = aux[7:4];
      fec = aux[3:0];
      a   = take_new();
      if (feb == NIB_NEW) bv = take_new();
      else bv = ring_back(feb);
      if (fec == NIB_NEW) c = take_new();
      else c = ring_back(fec);
      emit_triangle(a, bv, c);
      push_vertex(a, 1'b1);
      push_vertex(bv, feb == NIB_NEW);
      push_vertex(c, fec == NIB_NEW);
      push_edge(bv, a);
      push_edge(c, bv);
      push_edge(a, c);
    end else begin
      phase = PH_AUX;
    end
  endfunction

  function automatic void decode_aux(input logic [7:0] b);
    phase_t nxt;
    aux_reg = b;
    if (code_reg == CODE_AUX_NEW) corner[0] = take_new();
    else corner[0] = '0;
    if (b[7:4] == NIB_NEW) corner[1] = take_new();
    else corner[1] = ring_back(b[7:4]);
    if (b[3:0] == NIB_NEW) corner[2] = take_new();
    else corner[2] = ring_back(b[3:0]);
    nxt = explicit_from(0);
    if (nxt == PH_CODE) close_triangle();
    else start_groups(nxt);
  endfunction

  // one 7-bit group of a zigzag varint; the fifth group always ends it
  function automatic void decode_group(input logic [7:0] b);
    int               k;
    logic [63:0]      part;
    logic [IDX_W-1:0] delta;
    phase_t           nxt;
    k = (phase == PH_VAR0) ? 0 : (phase == PH_VAR1) ? 1 : 2;
    part = 64'(b[6:0]) << (7 * group_cnt);
    group_acc = group_acc | part[IDX_W-1:0];
    if ((b & GROUP_CONT) != 8'h00 && group_cnt != LAST_GROUP) begin
      group_cnt = group_cnt + 1'b1;
      return;
    end
    delta      = (group_acc >> 1) ^ {IDX_W{group_acc[0]}};
    last_index = last_index + delta;
    corner[k]  = last_index;
    group_acc  = '0;
    group_cnt  = '0;
    nxt = explicit_from(k + 1);
    if (nxt == PH_CODE) close_triangle();
    else phase = nxt;
  endfunction

  function automatic out_item_t decode_byte(input in_item_t it);
    logic want;
    want = (phase != PH_CODE);
    decode_result = '0;
    if (it.req_type != want) begin
      // wrong kind: ignored, request repeated
      decode_result.want_data  = want;
      decode_result.wrong_kind = 1'b1;
      return decode_result;
    end
    case (phase)
      PH_CODE: decode_code(it.in_byte);
      PH_AUX:  decode_aux(it.in_byte);
      default: decode_group(it.in_byte);
    endcase
    decode_result.want_data = (phase != PH_CODE);
    return decode_result;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // corner nibble biased toward new and explicit corners
  function automatic logic [3:0] pick_nibble();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return NIB_NEW;
    if (r < 50) return NIB_EXPLICIT;
    return 4'($urandom_range(0, 15));
  endfunction

  // next byte of a well-formed stream for the current phase, sometimes noise
  function automatic in_item_t stream_byte(input int noise_pct);
    in_item_t it;
    int       r;
    it.req_type = (phase != PH_CODE);
    r = $urandom_range(0, 99);
    case (phase)
      PH_CODE: begin
        if (r < 55) it.in_byte = {4'($urandom_range(0, 14)), pick_nibble()};
        else if (r < 80) it.in_byte = CODE_FIXED_MIN + 8'($urandom_range(0, 13));
        else if (r < 90) it.in_byte = CODE_AUX_NEW;
        else it.in_byte = CODE_AUX_EXPL;
      end
      PH_AUX: it.in_byte = {pick_nibble(), pick_nibble()};
      default: begin
        if (r < 60) it.in_byte = 8'($urandom_range(0, 127));
        else if (r < 90) it.in_byte = GROUP_CONT | 8'($urandom_range(0, 127));
        else it.in_byte = 8'hff;
      end
    endcase
    if ($urandom_range(0, 99) < noise_pct) begin
      it.req_type = ~it.req_type;
      it.in_byte  = 8'($urandom);
    end
    return it;
  endfunction

  // offer one item, predict its result on acceptance, then maybe idle
  task automatic send_byte(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(decode_byte(it));
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_stream(input int count, input int noise_pct);
    for (int i = 0; i < count; i++) send_byte(stream_byte(noise_pct));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_AUX_LOW:  aux_lo_cfg = val;
      REG_AUX_HIGH: aux_hi_cfg = val;
      REG_WIDE:     wide_cfg   = val[0];
      default:      total_cfg  = val[TOTAL_W-1:0];
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait for every predicted item to come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every code kind, wrong kinds in both phases, a five-group varint
  task automatic test_directed();
    logic [8:0] seq [24];
    seq = '{
      {KIND_DATA, 8'h00},                    // data byte while a code is wanted
      {KIND_CODE, 8'h00},                    // newest edge, new vertex
      {KIND_CODE, 8'h10},                    // older edge, new vertex
      {KIND_CODE, 8'h21},                    // third corner reused from the vertex ring
      {KIND_CODE, 4'h3, NIB_EXPLICIT},       // third corner explicit
      {KIND_CODE, 8'h00},                    // code byte while data is wanted
      {KIND_DATA, 8'hff},                    // five flagged groups, fifth ends the value
      {KIND_DATA, 8'hff},
      {KIND_DATA, 8'hff},
      {KIND_DATA, 8'hff},
      {KIND_DATA, 8'hff},
      {KIND_CODE, CODE_FIXED_MIN},           // aux entry 0
      {KIND_CODE, CODE_FIXED_MIN + 8'd2},    // aux entry 2: all corners new
      {KIND_CODE, CODE_FIXED_MIN + 8'd7},    // aux entry 7: deepest ring reuse
      {KIND_CODE, CODE_AUX_NEW - 8'd1},      // last fixed code, high aux word
      {KIND_CODE, CODE_AUX_NEW},
      {KIND_DATA, 8'h00},                    // aux byte: both remaining corners new
      {KIND_CODE, CODE_AUX_EXPL},
      {KIND_DATA, 8'hff},                    // aux byte: every corner explicit
      {KIND_DATA, 8'h01},                    // negative delta
      {KIND_DATA, 8'h80},                    // two-group value
      {KIND_DATA, 8'h00},
      {KIND_DATA, 8'h7f},
      {KIND_CODE, 8'hef}                     // deepest edge a code can reach, explicit; left open
    };
    write_reg(REG_AUX_LOW,  64'hff_f0_0f_11_23_00_01_32);
    write_reg(REG_AUX_HIGH, 64'h12_34_00_f0_0f_5a_3c_21);
    write_reg(REG_TOTAL,    64'd3);
    for (int i = 0; i < 24; i++) send_byte(in_item_t'(seq[i]));
    wait_idle();
  endtask

  // register extremes; the stream may stand mid-triangle across the writes
  task automatic test_extreme_config();
    write_reg(REG_AUX_LOW,  '1);
    write_reg(REG_AUX_HIGH, '1);
    write_reg(REG_WIDE,     '0);
    write_reg(REG_TOTAL,    64'hff_ffff);
    send_stream(40, 0);
    wait_idle();
    write_reg(REG_AUX_LOW,  '0);
    write_reg(REG_AUX_HIGH, '0);
    write_reg(REG_TOTAL,    '0);
    send_stream(30, 0);
    wait_idle();
    write_reg(REG_WIDE, 64'd1);
  endtask

  // last-triangle flag a few triangles ahead, with no idling at all
  task automatic test_last_triangle();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_reg(REG_AUX_LOW,  {$urandom, $urandom});
    write_reg(REG_AUX_HIGH, {$urandom, $urandom});
    write_reg(REG_TOTAL,    64'(tris_emitted + 24'd4));
    send_stream(40, 0);
    wait_idle();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // receiver holds off long enough that both stages fill and in_ready drops
  task automatic test_backpressure();
    tx_gaps_on         = 1'b0;
    long_stall_pending = 1'b1;
    send_stream(30, 0);
    tx_gaps_on = 1'b1;
    wait_idle();
    send_stream(20, 5);
    wait_idle();
  endtask

  // arbitrary kinds and bytes
  task automatic test_noise();
    in_item_t it;
    for (int i = 0; i < 40; i++) begin
      it = in_item_t'(9'($urandom));
      send_byte(it);
    end
    wait_idle();
  endtask

  // mostly well-formed streams under changing settings
  task automatic test_random();
    for (int round = 0; round < 8; round++) begin
      write_reg(REG_AUX_LOW,  {$urandom, $urandom});
      write_reg(REG_AUX_HIGH, {$urandom, $urandom});
      write_reg(REG_WIDE,     64'($urandom_range(0, 1)));
      write_reg(REG_TOTAL,    64'(tris_emitted + 24'($urandom_range(1, 20))));
      send_stream(45, 6);
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random short and long gaps, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_pending) begin
        long_stall_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string what, input out_item_t exp_i,
                                        input out_item_t got_i);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t %s: exp tv=%0d a=%h b=%h c=%h last=%0d want=%0d wk=%0d | got tv=%0d a=%h b=%h c=%h last=%0d want=%0d wk=%0d",
               $realtime, what,
               exp_i.tri_valid, exp_i.index_a, exp_i.index_b, exp_i.index_c,
               exp_i.last_triangle, exp_i.want_data, exp_i.wrong_kind,
               got_i.tri_valid, got_i.index_a, got_i.index_b, got_i.index_c,
               got_i.last_triangle, got_i.want_data, got_i.wrong_kind);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected item", '0, out_item);
      end else begin
        expected_item = pending_results.pop_front();
        if (out_item.tri_valid     !== expected_item.tri_valid     ||
            out_item.index_a       !== expected_item.index_a       ||
            out_item.index_b       !== expected_item.index_b       ||
            out_item.index_c       !== expected_item.index_c       ||
            out_item.last_triangle !== expected_item.last_triangle ||
            out_item.want_data     !== expected_item.want_data     ||
            out_item.wrong_kind    !== expected_item.wrong_kind)
          note_mismatch("mismatch", expected_item, out_item);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_extreme_config();
    test_last_triangle();
    test_backpressure();
    test_noise();
    test_random();
    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS triangle_index_stream_decoder_core");
    end else begin
      $display("FAIL triangle_index_stream_decoder_core");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL triangle_index_stream_decoder_core");
    $finish;
  end

endmodule

### filelist.f
design/tisd_pkg.sv
design/triangle_index_stream_decoder_core.sv
tb/tb_triangle_index_stream_decoder_core.sv
